// ===== hw/rtl/mahcp_pkg.sv =====
// mahcp_pkg: shared types, constants and character helpers for the
// mixed ascii/hex content parser; no dependencies
`default_nettype none

package mahcp_pkg;

  localparam int MAX_LEN = 1024;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0] MAX_LEN_V = LEN_W'(MAX_LEN);

  localparam logic [7:0] BAR_CHAR = 8'h7C;

  // parser state carried from one character to the next
  typedef struct packed {
    logic             hex_mode;
    logic             nibble_pending;
    logic [3:0]       high_nibble;
    logic [LEN_W-1:0] bytes_emitted;
  } mahcp_state_t;

  // one result request, fire = a result leaves for this character
  typedef struct packed {
    logic             fire;
    logic             byte_valid;
    logic [7:0]       data_byte;
    logic             end_of_content;
    logic [LEN_W-1:0] content_length;
    logic             empty_error;
    logic             skipped_invalid;
  } mahcp_result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;  // 'A'/'a' low nibble is 1
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mahcp_char_decode.sv =====
// mahcp_char_decode: per-character decode, next state and result request
// depends on mahcp_pkg
`default_nettype none

module mahcp_char_decode
  import mahcp_pkg::*;
(
  input  wire logic [7:0]    char_code,
  input  wire logic          is_final_char,
  input  wire mahcp_state_t  cur_state,
  output mahcp_state_t       next_state,
  output mahcp_result_t      result
);

  logic             valid;
  logic [7:0]       data;
  logic             skipped;
  logic             hex;
  logic [3:0]       v;
  logic [LEN_W-1:0] count;
  mahcp_state_t     st;

  always_comb begin
    st      = cur_state;
    valid   = 1'b0;
    data    = 8'h00;
    skipped = 1'b0;
    hex     = is_hex(char_code);
    v       = hex_val(char_code);

    if (!cur_state.hex_mode) begin
      if (char_code == BAR_CHAR) begin
        st.hex_mode = 1'b1;
      end else begin
        valid = 1'b1;
        data  = char_code;
      end
    end else if (cur_state.nibble_pending && hex) begin
      valid             = 1'b1;
      data              = {cur_state.high_nibble, v};
      st.nibble_pending = 1'b0;
    end else begin
      // a pending digit without a partner is dropped
      if (cur_state.nibble_pending) begin
        skipped           = 1'b1;
        st.nibble_pending = 1'b0;
      end
      if (char_code == BAR_CHAR) begin
        st.hex_mode = 1'b0;
      end else if (is_ws(char_code)) begin
        st.hex_mode = cur_state.hex_mode;
      end else if (hex) begin
        if (is_final_char) begin
          skipped = 1'b1;
        end else begin
          st.high_nibble    = v;
          st.nibble_pending = 1'b1;
        end
      end else begin
        skipped = 1'b1;
      end
    end

    count = cur_state.bytes_emitted;
    if (valid && (cur_state.bytes_emitted < MAX_LEN_V)) begin
      count = cur_state.bytes_emitted + LEN_W'(1);
    end
    st.bytes_emitted = count;

    result.fire            = valid || skipped || is_final_char;
    result.byte_valid      = valid;
    result.data_byte       = data;
    result.end_of_content  = is_final_char;
    result.content_length  = is_final_char ? count : '0;
    result.empty_error     = is_final_char && (count == '0);
    result.skipped_invalid = skipped;

    // end of string returns everything to reset
    if (is_final_char) begin
      next_state = '0;
    end else begin
      next_state = st;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mixed_ascii_hex_content_parser_top.sv =====
// an accepted character is registered in the input register, then its result in the result register
// throughput: one character per cycle while the result register is not held by out_stall; input register
// feeds decode, result register out; characters that produce nothing leave no result
// reset: synchronous active-low rst_n clears valids and parser state
// top level of the mixed ascii/hex content parser; depends on mahcp_pkg,
// mahcp_char_decode
`default_nettype none

module mixed_ascii_hex_content_parser_top
  import mahcp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [7:0]       in_char_code,
  input  wire logic             in_is_final_char,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic             out_byte_valid,
  output      logic [7:0]       out_data_byte,
  output      logic             out_end_of_content,
  output      logic [LEN_W-1:0] out_content_length,
  output      logic             out_empty_error,
  output      logic             out_skipped_invalid
);

  logic          s1_valid_r, s1_valid_nxt;
  logic [7:0]    s1_char_r;
  logic          s1_last_r;
  mahcp_state_t  state_r, state_nxt;
  mahcp_result_t res_r;
  logic          res_valid_r, res_valid_nxt;
  mahcp_state_t  dec_state;
  mahcp_result_t dec_res;
  logic          out_free;
  logic          s1_go;
  logic          in_take;

  mahcp_char_decode u_decode (
    .char_code     (s1_char_r),
    .is_final_char (s1_last_r),
    .cur_state     (state_r),
    .next_state    (dec_state),
    .result        (dec_res)
  );

  // result register is free when empty or being taken this cycle
  assign out_free = !res_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !s1_go);
    state_nxt     = s1_go ? dec_state : state_r;
    res_valid_nxt = res_valid_r && out_stall;
    if (s1_go) begin
      res_valid_nxt = dec_res.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_code;
      s1_last_r <= in_is_final_char;
    end
    if (s1_go && dec_res.fire) begin
      res_r <= dec_res;
    end
  end

  assign out_valid           = res_valid_r;
  assign out_byte_valid      = res_r.byte_valid;
  assign out_data_byte       = res_r.data_byte;
  assign out_end_of_content  = res_r.end_of_content;
  assign out_content_length  = res_r.content_length;
  assign out_empty_error     = res_r.empty_error;
  assign out_skipped_invalid = res_r.skipped_invalid;

endmodule

`default_nettype wire

// ===== hw/rtl/mahcp_checker.sv =====
// mahcp_checker: port-level assertions for the content parser top level,
// bound to it below; depends on mahcp_pkg
`default_nettype none

module mahcp_checker
  import mahcp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_byte_valid,
  input wire logic [7:0]       out_data_byte,
  input wire logic             out_end_of_content,
  input wire logic [LEN_W-1:0] out_content_length,
  input wire logic             out_empty_error,
  input wire logic             out_skipped_invalid
);

  // a stalled request stays and keeps its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte))
    else $error("result request changed while stalled");

  // a mid-string result always carries a byte or a drop
  a_not_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_content |->
      (out_byte_valid || out_skipped_invalid) && out_content_length == '0)
    else $error("mid-string result with no byte and no drop");

  // a result never carries both a byte and a drop
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_byte_valid && out_skipped_invalid))
    else $error("byte and drop on same result");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_error |->
      out_end_of_content && out_content_length == '0 && !out_byte_valid)
    else $error("empty error with bytes present");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_content_length <= MAX_LEN_V &&
      (out_byte_valid || out_data_byte == 8'h00))
    else $error("length over limit or stray byte value");

endmodule

bind mixed_ascii_hex_content_parser_top mahcp_checker u_mahcp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_byte_valid      (out_byte_valid),
  .out_data_byte       (out_data_byte),
  .out_end_of_content  (out_end_of_content),
  .out_content_length  (out_content_length),
  .out_empty_error     (out_empty_error),
  .out_skipped_invalid (out_skipped_invalid)
);

`default_nettype wire
